// File: design/assert_macros.svh
// Assertion macros shared by the frame parser RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define SFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SFP_ASSERT(label, clk, rst_n, prop, msg)
`define SFP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// File: design/sfp_pkg.sv
// Types, codes and helpers of the sensor frame parser.
// No dependencies; the top level, front end, queue and back end import it.
`default_nettype none

package sfp_pkg;

    localparam int unsigned HEADER_LAST = 6;   // header is bytes 0..6
    localparam int unsigned INNER_EXTRA = 4;   // inner length + 4 == payload length

    // configuration register indexes
    localparam logic [1:0] CFG_PACKAGE_START  = 2'd0;
    localparam logic [1:0] CFG_PACKAGE_END    = 2'd1;
    localparam logic [1:0] CFG_CONTENTS_START = 2'd2;
    localparam logic [1:0] CFG_CONTENTS_END   = 2'd3;

    localparam logic [7:0] RST_PACKAGE_START  = 8'hF1;
    localparam logic [7:0] RST_PACKAGE_END    = 8'hFD;
    localparam logic [7:0] RST_CONTENTS_START = 8'hA1;
    localparam logic [7:0] RST_CONTENTS_END   = 8'hED;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_MARKER = 2'd1;
    localparam logic [1:0] STATUS_LENGTH = 2'd2;

    localparam logic [1:0] SESSION_NONE    = 2'd0;
    localparam logic [1:0] SESSION_FAILED  = 2'd1;
    localparam logic [1:0] SESSION_SUCCESS = 2'd2;

    typedef enum logic {
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    // what a byte means, decided by the front end
    typedef enum logic [3:0] {
        K_START,
        K_KEY,
        K_LEN_LO,
        K_LEN_HI,
        K_PAY_MARK,
        K_PAY_LEN_LO,
        K_PAY_LEN_HI,
        K_PAY_TYPE,
        K_PAY_BODY,
        K_END
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_qitem;

    typedef struct packed {
        logic [7:0] package_start;
        logic [7:0] package_end;
        logic [7:0] contents_start;
        logic [7:0] contents_end;
    } t_cfg;

    typedef struct packed {
        logic [31:0] frame_key;
        logic [7:0]  message_type;
        logic [1:0]  frame_status;
        logic        start_mismatch;
        logic        end_mismatch;
        logic [15:0] payload_length;
        logic [31:0] failed_total;
        logic [31:0] accepted_total;
        logic [31:0] bytes_total;
        logic [1:0]  session_state;
    } t_result;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

// File: design/sfp_if.sv
// Stream interfaces of the parser: byte input and frame result output.
// Valid/ready handshake; no package dependency.
`default_nettype none

interface sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source(output valid, output data_byte, input ready);
    modport sink(input valid, input data_byte, output ready);
endinterface

interface sfp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_key;
    logic [7:0]  message_type;
    logic [1:0]  frame_status;
    logic        start_mismatch;
    logic        end_mismatch;
    logic [15:0] payload_length;
    logic [31:0] failed_total;
    logic [31:0] accepted_total;
    logic [31:0] bytes_total;
    logic [1:0]  session_state;

    modport source(output valid, output frame_key, output message_type,
                   output frame_status, output start_mismatch, output end_mismatch,
                   output payload_length, output failed_total, output accepted_total,
                   output bytes_total, output session_state, input ready);
    modport sink(input valid, input frame_key, input message_type,
                 input frame_status, input start_mismatch, input end_mismatch,
                 input payload_length, input failed_total, input accepted_total,
                 input bytes_total, input session_state, output ready);
endinterface

`default_nettype wire

// File: design/sensor_frame_parser.sv
// Top level of the sensor frame parser: config registers, front end, queue, back end.
// Uses sfp_pkg, sfp_if, sfp_front, sfp_queue, sfp_back.
//
//  port      dir  handshake      carries
//  i_in      in   valid/ready    data_byte, one stream byte per item
//  o_res     out  valid/ready    one frame result per end byte
//  i_cfg_*   in   write enable   register index and 8-bit value
//
// One byte per cycle sustained while the queue has space; the front end classifies in the cycle it accepts,
// the back end applies the byte the next cycle or later from the queue.
// An end byte reaches the result through the queue register and then the result register.
// Reset is synchronous and restores the default markers and clears all counters.
// A stalled result holds an end byte and the bytes queued behind it; earlier bytes drain into frame state.
`default_nettype none

module sensor_frame_parser #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfp_byte_if.sink         i_in,
    sfp_result_if.source     o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data
);
    import sfp_pkg::*;

    t_cfg    r_cfg;
    logic    w_space, w_push, w_q_valid, w_pop, w_out_valid;
    t_qitem  w_push_item, w_q_item;
    t_result w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.package_start  <= RST_PACKAGE_START;
            r_cfg.package_end    <= RST_PACKAGE_END;
            r_cfg.contents_start <= RST_CONTENTS_START;
            r_cfg.contents_end   <= RST_CONTENTS_END;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PACKAGE_START:  r_cfg.package_start  <= i_cfg_data;
                CFG_PACKAGE_END:    r_cfg.package_end    <= i_cfg_data;
                CFG_CONTENTS_START: r_cfg.contents_start <= i_cfg_data;
                CFG_CONTENTS_END:   r_cfg.contents_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_data  (i_in.data_byte),
        .i_space (w_space),
        .o_ready (i_in.ready),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    sfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_pop       (w_pop),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .o_out       (w_out)
    );

    assign o_res.valid          = w_out_valid;
    assign o_res.frame_key      = w_out.frame_key;
    assign o_res.message_type   = w_out.message_type;
    assign o_res.frame_status   = w_out.frame_status;
    assign o_res.start_mismatch = w_out.start_mismatch;
    assign o_res.end_mismatch   = w_out.end_mismatch;
    assign o_res.payload_length = w_out.payload_length;
    assign o_res.failed_total   = w_out.failed_total;
    assign o_res.accepted_total = w_out.accepted_total;
    assign o_res.bytes_total    = w_out.bytes_total;
    assign o_res.session_state  = w_out.session_state;

endmodule

`default_nettype wire

// File: design/sfp_front.sv
// Front end: tracks frame position and tags each accepted byte with its role.
// Uses sfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_space,    // queue can take an item
    output logic                o_ready,
    output logic                o_push,
    output sfp_pkg::t_qitem     o_item
);
    import sfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_len_lo, n_len_lo;
    logic [15:0] r_len, n_len;
    t_kind       w_kind;
    logic        w_accept;

    assign o_ready  = i_space;
    assign w_accept = i_valid && i_space;

    // role of the byte at the current position
    always_comb begin
        w_kind = K_START;
        case (r_phase)
            PH_HEADER: begin
                if (r_pos == 16'd0)      w_kind = K_START;
                else if (r_pos <= 16'd4) w_kind = K_KEY;
                else if (r_pos == 16'd5) w_kind = K_LEN_LO;
                else                     w_kind = K_LEN_HI;
            end
            PH_PAYLOAD: begin
                if (r_pos >= r_len)      w_kind = K_END;
                else if (r_pos == 16'd0) w_kind = K_PAY_MARK;
                else if (r_pos == 16'd1) w_kind = K_PAY_LEN_LO;
                else if (r_pos == 16'd2) w_kind = K_PAY_LEN_HI;
                else if (r_pos == 16'd3) w_kind = K_PAY_TYPE;
                else                     w_kind = K_PAY_BODY;
            end
            default: w_kind = K_START;
        endcase
    end

    always_comb begin
        o_push      = w_accept;
        o_item.kind = w_kind;
        o_item.data = i_data;
    end

    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_HEADER:  if (w_accept && w_kind == K_LEN_HI) n_phase = PH_PAYLOAD;
            PH_PAYLOAD: if (w_accept && w_kind == K_END)    n_phase = PH_HEADER;
            default:    n_phase = PH_HEADER;
        endcase
    end

    always_comb begin
        n_pos    = r_pos;
        n_len_lo = r_len_lo;
        n_len    = r_len;
        if (w_accept) begin
            if (w_kind == K_LEN_HI || w_kind == K_END) n_pos = 16'd0;
            else                                         n_pos = r_pos + 16'd1;
            if (w_kind == K_LEN_LO) n_len_lo = i_data;
            if (w_kind == K_LEN_HI) n_len    = {i_data, r_len_lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_pos    <= 16'd0;
            r_len_lo <= 8'd0;
            r_len    <= 16'd0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_len_lo <= n_len_lo;
            r_len    <= n_len;
        end
    end

    `SFP_ASSERT(a_header_pos, i_clk, i_rst_n, (r_phase == PH_HEADER) |-> (r_pos <= 16'(HEADER_LAST)), "header position ran past the header")
    `SFP_ASSERT(a_payload_pos, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_pos <= r_len), "payload position ran past the length")

endmodule

`default_nettype wire

// File: design/sfp_queue.sv
// Short flop queue of tagged bytes between front and back end.
// Uses sfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire sfp_pkg::t_qitem i_item,
    input  wire logic            i_pop,
    output logic                 o_space,
    output logic                 o_valid,
    output sfp_pkg::t_qitem      o_item
);
    import sfp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_qitem        r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_space = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        if (i_pop)  n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        if (i_push && !i_pop)      n_count = r_count + CW'(1);
        else if (!i_push && i_pop) n_count = r_count - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_item;
    end

    `SFP_ASSERT(a_no_overflow, i_clk, i_rst_n, i_push |-> o_space, "push into a full queue")
    `SFP_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "pop from an empty queue")

endmodule

`default_nettype wire

// File: design/sfp_back.sv
// Back end: applies tagged bytes to frame state, checks, counts, holds the result.
// Uses sfp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sfp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sfp_pkg::t_cfg   i_cfg,
    input  wire logic            i_q_valid,
    input  wire sfp_pkg::t_qitem i_q_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output sfp_pkg::t_result     o_out
);
    import sfp_pkg::*;

    logic [31:0] r_key;
    logic [15:0] r_len;
    logic        r_first_ok;
    logic [15:0] r_inner;
    logic [7:0]  r_type;
    logic [7:0]  r_prev;
    logic        r_start_bad;
    logic [31:0] r_fail, n_fail;
    logic [31:0] r_succ, n_succ;
    logic [31:0] r_bytes, n_bytes;
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        w_end;
    logic [1:0]  w_status;
    logic [7:0]  b;

    assign b     = i_q_item.data;
    assign w_end = (i_q_item.kind == K_END);
    // an end byte waits until the result register is free
    assign o_pop = i_q_valid && (!w_end || !r_out_valid || i_out_ready);

    always_comb begin
        if (r_len == 16'd0 || !r_first_ok || r_prev != i_cfg.contents_end)
            w_status = STATUS_MARKER;
        else if (({1'b0, r_inner} + 17'(INNER_EXTRA)) != {1'b0, r_len})
            w_status = STATUS_LENGTH;
        else
            w_status = STATUS_OK;
    end

    always_comb begin
        n_bytes = sat_inc(r_bytes);
        n_succ  = r_succ;
        n_fail  = r_fail;
        if (w_end) begin
            if (w_status == STATUS_OK) n_succ = sat_inc(r_succ);
            else                       n_fail = sat_inc(r_fail);
        end
        n_out.frame_key      = r_key;
        n_out.message_type   = (w_status == STATUS_OK) ? r_type : 8'd0;
        n_out.frame_status   = w_status;
        n_out.start_mismatch = r_start_bad;
        n_out.end_mismatch   = (b != i_cfg.package_end);
        n_out.payload_length = r_len;
        n_out.failed_total   = n_fail;
        n_out.accepted_total = n_succ;
        n_out.bytes_total    = n_bytes;
        if (n_succ != 32'd0)      n_out.session_state = SESSION_SUCCESS;
        else if (n_fail != 32'd0) n_out.session_state = SESSION_FAILED;
        else                      n_out.session_state = SESSION_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= 32'd0;
            r_len       <= 16'd0;
            r_first_ok  <= 1'b0;
            r_inner     <= 16'd0;
            r_type      <= 8'd0;
            r_prev      <= 8'd0;
            r_start_bad <= 1'b0;
            r_fail      <= 32'd0;
            r_succ      <= 32'd0;
            r_bytes     <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_bytes <= n_bytes;
                r_fail  <= n_fail;
                r_succ  <= n_succ;
                r_prev  <= b;
                case (i_q_item.kind)
                    K_START:      r_start_bad <= (b != i_cfg.package_start);
                    K_KEY:        r_key       <= {b, r_key[31:8]};
                    K_LEN_LO:     r_len       <= {8'd0, b};
                    K_LEN_HI: begin
                        r_len      <= {b, r_len[7:0]};
                        r_first_ok <= 1'b0;
                        r_inner    <= 16'd0;
                        r_type     <= 8'd0;
                    end
                    K_PAY_MARK:   r_first_ok  <= (b == i_cfg.contents_start);
                    K_PAY_LEN_LO: r_inner     <= {r_inner[15:8], b};
                    K_PAY_LEN_HI: r_inner     <= {b, r_inner[7:0]};
                    K_PAY_TYPE:   r_type      <= b;
                    default: ;
                endcase
            end
            if (o_pop && w_end)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_end) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `SFP_ASSERT(a_end_gives_result, i_clk, i_rst_n, (o_pop && w_end) |=> r_out_valid, "end byte consumed without a result")
    `SFP_ASSERT(a_no_overwrite, i_clk, i_rst_n, (o_pop && w_end && r_out_valid) |-> i_out_ready, "pending result overwritten")

endmodule

`default_nettype wire
